### src/per_flow_token_bucket_limiter_macros.svh
// Assertion macros shared by the limiter checker.
`ifndef PER_FLOW_TOKEN_BUCKET_LIMITER_MACROS_SVH
`define PER_FLOW_TOKEN_BUCKET_LIMITER_MACROS_SVH

// Clocked property, disabled during reset.
`define PFTB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("limiter check failed");

// Condition that must never be seen at a clock edge.
`define PFTB_ASSERT_NEVER(lbl, cond) \
  `PFTB_ASSERT(lbl, !(cond))

`endif

### src/pftb_pkg.sv
// Types and constants of the per-flow token bucket limiter.
`timescale 1ns / 1ps
package pftb_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_REQ   = 2'd1,
    OP_RESET = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_RATE     = 2'd1,
    CFG_INTERVAL = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP_RD,
    ST_SWEEP_CHK,
    ST_READ,
    ST_LOAD,
    ST_REFILL,
    ST_CONSUME,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam int unsigned ONE_TOKEN = 32'h0001_0000;
  localparam int unsigned DIV_STEPS = 17;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic sweep_rd;
    logic sweep_chk;
    logic read;
    logic load;
    logic refill;
    logic consume;
    logic prep;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
    logic need_div;
    logic div_done;
  } status_t;

endpackage

### src/pftb_div.sv
// Restoring divider, one quotient bit per cycle, rounds the quotient up.
`timescale 1ns / 1ps
module pftb_div
  import pftb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [16:0] quot_o
);

  logic [32:0] rem_q, rem_d;
  logic [16:0] q_q, q_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], q_q[16]};
    if (start_i) begin
      rem_d = '0;
      q_d   = dividend_i;
      cnt_d = 5'(DIV_STEPS);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        q_d   = {q_q[15:0], 1'b1};
      end else begin
        rem_d = trial;
        q_d   = {q_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
  end

  assign done_o = done_q;
  // q stays below the dividend whenever a remainder is left, so no overflow
  assign quot_o = q_q + {16'd0, (rem_q != '0)};

endmodule

### src/pftb_ctrl.sv
// Sequencer of the limiter: sweeps, read-modify-write and retry division.
`timescale 1ns / 1ps
module pftb_ctrl
  import pftb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic [1:0] opcode_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = !(state_q == ST_IDLE || state_q == ST_DONE);
    done_o  = (state_q == ST_DONE);
    accept  = start_i && !busy_o;
    cmd_o.accept = accept;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        state_d = ST_IDLE;
        if (accept) begin
          if (opcode_i == OP_REQ) begin
            state_d = status_i.need_sweep ? ST_SWEEP_RD : ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SWEEP_RD: begin
        cmd_o.sweep_rd = 1'b1;
        state_d = ST_SWEEP_CHK;
      end
      ST_SWEEP_CHK: begin
        cmd_o.sweep_chk = 1'b1;
        state_d = status_i.sweep_last ? ST_READ : ST_SWEEP_RD;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = ST_REFILL;
      end
      ST_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d = ST_CONSUME;
      end
      ST_CONSUME: begin
        cmd_o.consume = 1'b1;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = status_i.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_DONE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### src/pftb_dp.sv
// Limiter datapath: bucket table, counters, refill arithmetic and registers.
`timescale 1ns / 1ps
module pftb_dp
  import pftb_pkg::*;
#(
  parameter int unsigned FLOW_ENTRIES = 256,
  parameter int unsigned TICK_BITS    = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  flow_key_i,
  input  logic [15:0] request_tokens_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        allowed_o,
  output logic [16:0] retry_ticks_o,
  output logic [8:0]  bucket_count_o,
  output logic [31:0] request_count_o,
  output logic [31:0] limited_count_o
);

  localparam int unsigned IDX_W = $clog2(FLOW_ENTRIES);
  localparam int unsigned CNT_W = $clog2(FLOW_ENTRIES + 1);
  localparam int unsigned CW    = (TICK_BITS > 32) ? TICK_BITS : 32;

  logic [15:0] cap_q;
  logic [31:0] rate_q, intv_q;
  logic [TICK_BITS-1:0] tick_q, last_sweep_q;
  logic [31:0] req_q, den_q;
  logic [FLOW_ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] idx_q, ptr_q, key_idx, rd_addr;
  logic [15:0] want_q;
  logic [31:0] mem_level [FLOW_ENTRIES];
  logic [TICK_BITS-1:0] mem_stamp [FLOW_ENTRIES];
  logic [31:0] rd_level_q;
  logic [TICK_BITS-1:0] rd_stamp_q;
  logic [31:0] lvl_q;
  logic [63:0] prod_q;
  logic        big_q;
  logic        allowed_q;
  logic [16:0] retry_q;
  logic        div_start, div_done;
  logic [16:0] div_quot;
  logic [31:0] full, room, want32;
  logic [31:0] src_level;
  logic [TICK_BITS-1:0] src_stamp, elapsed;
  logic [CW-1:0] elapsed_ext, since_sweep;
  logic [CW-1:0] intv_ext;
  logic          wr_en, mem_rd;
  logic [31:0]   wr_level;

  assign key_idx  = IDX_W'(flow_key_i % FLOW_ENTRIES);
  assign full     = {cap_q, 16'd0};
  assign want32   = {want_q, 16'd0};
  assign room     = full - lvl_q;
  assign intv_ext = CW'(intv_q);
  assign since_sweep = CW'(tick_q - last_sweep_q);

  assign src_level   = valid_q[idx_q] ? rd_level_q : full;
  assign src_stamp   = valid_q[idx_q] ? rd_stamp_q : tick_q;
  assign elapsed     = tick_q - src_stamp;
  assign elapsed_ext = CW'(elapsed);

  assign status_o.need_sweep = (since_sweep >= intv_ext);
  assign status_o.sweep_last = (ptr_q == IDX_W'(FLOW_ENTRIES - 1));
  assign status_o.need_div   = (lvl_q[31:16] == 16'd0) && (rate_q != 32'd0);
  assign status_o.div_done   = div_done;

  assign div_start = cmd_i.prep && status_o.need_div;
  assign mem_rd    = cmd_i.sweep_rd || cmd_i.read;
  assign rd_addr   = cmd_i.sweep_rd ? ptr_q : idx_q;
  assign wr_en     = cmd_i.consume;
  assign wr_level  = (lvl_q >= want32) ? (lvl_q - want32) : lvl_q;

  pftb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (17'(ONE_TOKEN) - {1'b0, lvl_q[15:0]}),
    .divisor_i  (rate_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Bucket table, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_level[idx_q] <= wr_level;
      mem_stamp[idx_q] <= tick_q;
    end
    if (mem_rd) begin
      rd_level_q <= mem_level[rd_addr];
      rd_stamp_q <= mem_stamp[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= 16'd100;
      rate_q       <= 32'd65536;
      intv_q       <= 32'd60;
      tick_q       <= '0;
      last_sweep_q <= '0;
      req_q        <= '0;
      den_q        <= '0;
      valid_q      <= '0;
      cnt_q        <= '0;
      ptr_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CAPACITY: cap_q  <= cfg_data_i[15:0];
          CFG_RATE:     rate_q <= cfg_data_i;
          CFG_INTERVAL: intv_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        ptr_q <= '0;
        case (opcode_i)
          OP_TICK: tick_q <= tick_q + 1'b1;
          OP_REQ: begin
            if (req_q != 32'hFFFF_FFFF) req_q <= req_q + 32'd1;
            if (status_o.need_sweep) last_sweep_q <= tick_q;
          end
          OP_RESET: begin
            if (valid_q[key_idx]) begin
              valid_q[key_idx] <= 1'b0;
              cnt_q <= cnt_q - 1'b1;
            end
          end
          default: begin
            valid_q <= '0;
            cnt_q   <= '0;
            req_q   <= '0;
            den_q   <= '0;
          end
        endcase
      end
      if (cmd_i.sweep_chk) begin
        // drop buckets whose stored whole level reached capacity
        if (valid_q[ptr_q] && (rd_level_q[31:16] >= cap_q)) begin
          valid_q[ptr_q] <= 1'b0;
          cnt_q <= cnt_q - 1'b1;
        end
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.load && !valid_q[idx_q]) begin
        valid_q[idx_q] <= 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.consume && (lvl_q < want32) && (den_q != 32'hFFFF_FFFF)) begin
        den_q <= den_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q     <= key_idx;
      want_q    <= request_tokens_i;
      allowed_q <= 1'b0;
      retry_q   <= '0;
    end
    if (cmd_i.load) begin
      lvl_q  <= src_level;
      prod_q <= elapsed_ext[31:0] * rate_q;
      // an elapsed count past 32 bits always overfills the bucket when the rate is nonzero
      big_q  <= (elapsed_ext >> 32) != '0;
    end
    if (cmd_i.refill) begin
      if (lvl_q >= full) begin
        lvl_q <= full;
      end else if (rate_q != 32'd0) begin
        if (big_q || (prod_q > {32'd0, room})) lvl_q <= full;
        else lvl_q <= lvl_q + prod_q[31:0];
      end
    end
    if (cmd_i.consume) begin
      lvl_q     <= wr_level;
      allowed_q <= (lvl_q >= want32);
    end
    if (cmd_i.prep && (lvl_q[31:16] == 16'd0) && (rate_q == 32'd0)) begin
      retry_q <= 17'h1_0000;
    end
    if (div_done) retry_q <= div_quot;
  end

  assign allowed_o       = allowed_q;
  assign retry_ticks_o   = retry_q;
  assign bucket_count_o  = 9'(cnt_q);
  assign request_count_o = req_q;
  assign limited_count_o = den_q;

endmodule

### src/per_flow_token_bucket_limiter.sv
// Top level of the per-flow token bucket limiter.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive opcode_i, flow_key_i, request_tokens_i with start;
//   the command transfers at a clock edge where start is high and busy low.
//   Each command gives one result, shown for exactly one cycle with done_o.
//   busy is low in that result cycle, so a new command may follow at once.
//   Tick, reset flow and clear all: result in the cycle after the transfer.
//   Request: read, refill multiply, refill, consume, then a 17-step retry
//   division when under one token and the rate is nonzero.
//   When the cleanup interval has elapsed a request first sweeps the table,
//   reading and checking each entry in turn over the single memory read port.
//   Configuration: cfg_valid_i / cfg_ready_o transfer cfg_index_i, cfg_data_i;
//   write only while no command is in flight.
//   Reset clears all buckets, counters and time and loads default registers.
//   The receiver cannot stall: a result is gone after its one cycle.
module per_flow_token_bucket_limiter
  import pftb_pkg::*;
#(
  parameter int unsigned FLOW_ENTRIES = 256,
  parameter int unsigned TICK_BITS    = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  flow_key_i,
  input  logic [15:0] request_tokens_i,
  output logic        done_o,
  output logic        allowed_o,
  output logic [16:0] retry_ticks_o,
  output logic [8:0]  bucket_count_o,
  output logic [31:0] request_count_o,
  output logic [31:0] limited_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  pftb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  pftb_dp #(
    .FLOW_ENTRIES (FLOW_ENTRIES),
    .TICK_BITS    (TICK_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (opcode_i),
    .flow_key_i       (flow_key_i),
    .request_tokens_i (request_tokens_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .allowed_o        (allowed_o),
    .retry_ticks_o    (retry_ticks_o),
    .bucket_count_o   (bucket_count_o),
    .request_count_o  (request_count_o),
    .limited_count_o  (limited_count_o)
  );

endmodule

### src/pftb_checker.sv
// Port-level checks of the limiter and their bind to the top level.
`timescale 1ns / 1ps
`include "per_flow_token_bucket_limiter_macros.svh"
module pftb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        done_o,
  input logic        allowed_o,
  input logic [16:0] retry_ticks_o,
  input logic [31:0] request_count_o,
  input logic [31:0] limited_count_o
);

  `PFTB_ASSERT_NEVER(a_done_busy, done_o && busy)
  `PFTB_ASSERT(a_denied_le_seen, done_o |-> (limited_count_o <= request_count_o))
  `PFTB_ASSERT(a_retry_range, done_o |-> (retry_ticks_o <= 17'h1_0000))
  `PFTB_ASSERT(a_allow_counted, (done_o && allowed_o) |-> (request_count_o != 32'd0))

endmodule

bind per_flow_token_bucket_limiter pftb_checker u_pftb_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the per-flow token bucket limiter.
`timescale 1ns / 1ps
module testbench
  import pftb_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 40;

  typedef struct packed {
    logic        allowed;
    logic [16:0] retry;
    logic [8:0]  count;
    logic [31:0] reqs;
    logic [31:0] denied;
  } result_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  key;
    logic [15:0] tok;
    logic        typed;
    result_t     res;
  } row_t;

  typedef struct {
    logic [15:0] cap;
    logic [31:0] rate;
    logic [31:0] interval;
    int          items;
  } phase_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = OP_TICK;
  logic [7:0]  flow_key_i = '0;
  logic [15:0] request_tokens_i = '0;
  logic        done_o;
  logic        allowed_o;
  logic [16:0] retry_ticks_o;
  logic [8:0]  bucket_count_o;
  logic [31:0] request_count_o;
  logic [31:0] limited_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_CAPACITY;
  logic [31:0] cfg_data_i = '0;

  per_flow_token_bucket_limiter DUT (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state
  logic [15:0] cap_q;
  logic [31:0] rate_q;
  logic [31:0] interval_q;
  logic        bkt_valid [256];
  logic [31:0] bkt_level [256];
  logic [47:0] bkt_stamp [256];
  logic [47:0] now_tick;
  logic [47:0] last_sweep;
  logic [31:0] seen_cnt;
  logic [31:0] denied_cnt;

  result_t pending_results[$];
  int      errors = 0;
  int      quiet_cycles = 0;

  task automatic bucket_step(input op_e op, input logic [7:0] key, input logic [15:0] tok,
                             output result_t r);
    logic [63:0] full;
    logic [63:0] lvl;
    logic [63:0] room;
    logic [63:0] need;
    logic [63:0] want;
    logic [47:0] elapsed;
    logic [47:0] since_sweep;
    r = '0;
    full = {48'd0, cap_q} << 16;
    want = {48'd0, tok} << 16;
    case (op)
      OP_TICK: now_tick = now_tick + 48'd1;
      OP_REQ: begin
        if (seen_cnt != 32'hFFFF_FFFF) seen_cnt++;
        since_sweep = now_tick - last_sweep;
        if ({16'd0, since_sweep} >= {32'd0, interval_q}) begin
          for (int i = 0; i < 256; i++)
            if (bkt_valid[i] && bkt_level[i][31:16] >= cap_q) bkt_valid[i] = 1'b0;
          last_sweep = now_tick;
        end
        if (!bkt_valid[key]) begin
          bkt_valid[key] = 1'b1;
          bkt_level[key] = full[31:0];
          bkt_stamp[key] = now_tick;
        end
        elapsed = now_tick - bkt_stamp[key];
        lvl = {32'd0, bkt_level[key]};
        if (lvl >= full) begin
          lvl = full;
        end else if (rate_q != 0) begin
          room = full - lvl;
          if ({16'd0, elapsed} > room / rate_q) lvl = full;
          else lvl = lvl + {16'd0, elapsed} * {32'd0, rate_q};
          if (lvl > full) lvl = full;
        end
        bkt_stamp[key] = now_tick;
        if (lvl >= want) begin
          lvl = lvl - want;
          r.allowed = 1'b1;
        end else if (denied_cnt != 32'hFFFF_FFFF) begin
          denied_cnt++;
        end
        bkt_level[key] = lvl[31:0];
        if (lvl < ONE_TOKEN) begin
          need = ONE_TOKEN - lvl;
          if (rate_q == 0) r.retry = 17'd65536;
          else r.retry = 17'((need + rate_q - 1) / rate_q);
        end
      end
      OP_RESET: bkt_valid[key] = 1'b0;
      default: begin
        for (int i = 0; i < 256; i++) bkt_valid[i] = 1'b0;
        seen_cnt = '0;
        denied_cnt = '0;
      end
    endcase
    for (int i = 0; i < 256; i++) r.count += 9'(bkt_valid[i]);
    r.reqs = seen_cnt;
    r.denied = denied_cnt;
  endtask

  // Holds start across back-to-back commands; returns right after the transfer edge.
  task automatic issue(input op_e op, input logic [7:0] key, input logic [15:0] tok,
                       input logic typed, input result_t typed_res);
    result_t r;
    start <= 1'b1;
    opcode_i <= op;
    flow_key_i <= key;
    request_tokens_i <= tok;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    bucket_step(op, key, tok, r);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_CAPACITY: cap_q = data[15:0];
      CFG_RATE:     rate_q = data;
      CFG_INTERVAL: interval_q = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly a few hot flows and small requests so buckets get reused and drained.
  task automatic random_item(output op_e op, output logic [7:0] key, output logic [15:0] tok);
    int p;
    p = $urandom_range(99);
    op = p < 35 ? OP_TICK : p < 88 ? OP_REQ : p < 97 ? OP_RESET : OP_CLEAR;
    key = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    p = $urandom_range(9);
    if (p == 0) tok = 16'($urandom);
    else if (p < 3) tok = 16'($urandom_range(32'(cap_q) + 1));
    else tok = 16'($urandom_range(3));
  endtask

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (allowed_o !== e.allowed) begin
          $error("allowed: expected %0d, got %0d", e.allowed, allowed_o); errors++;
        end
        if (retry_ticks_o !== e.retry) begin
          $error("retry_ticks: expected %0d, got %0d", e.retry, retry_ticks_o); errors++;
        end
        if (bucket_count_o !== e.count) begin
          $error("bucket_count: expected %0d, got %0d", e.count, bucket_count_o); errors++;
        end
        if (request_count_o !== e.reqs) begin
          $error("request_count: expected %0d, got %0d", e.reqs, request_count_o); errors++;
        end
        if (limited_count_o !== e.denied) begin
          $error("limited_count: expected %0d, got %0d", e.denied, limited_count_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  row_t   script[8];
  phase_t phases[9];

  initial begin
    op_e         op;
    logic [7:0]  key;
    logic [15:0] tok;
    int          burst;
    cap_q = 16'd100;
    rate_q = 32'd65536;
    interval_q = 32'd60;
    now_tick = '0;
    last_sweep = '0;
    seen_cnt = '0;
    denied_cnt = '0;
    for (int i = 0; i < 256; i++) begin
      bkt_valid[i] = 1'b0;
      bkt_level[i] = '0;
      bkt_stamp[i] = '0;
    end
    // Reset defaults: capacity 100, one token per tick, sweep every 60 ticks.
    script[0] = '{OP_REQ,   8'd0,   16'd0,     1'b1, '{1'b1, 17'd0, 9'd1, 32'd1, 32'd0}};
    script[1] = '{OP_REQ,   8'd255, 16'hFFFF,  1'b1, '{1'b0, 17'd0, 9'd2, 32'd2, 32'd1}};
    script[2] = '{OP_REQ,   8'd255, 16'd100,   1'b1, '{1'b1, 17'd1, 9'd2, 32'd3, 32'd1}};
    script[3] = '{OP_TICK,  8'd0,   16'd0,     1'b1, '{1'b0, 17'd0, 9'd2, 32'd3, 32'd1}};
    script[4] = '{OP_REQ,   8'd255, 16'd1,     1'b1, '{1'b1, 17'd1, 9'd2, 32'd4, 32'd1}};
    script[5] = '{OP_REQ,   8'd255, 16'd1,     1'b1, '{1'b0, 17'd1, 9'd2, 32'd5, 32'd2}};
    script[6] = '{OP_RESET, 8'd255, 16'd0,     1'b1, '{1'b0, 17'd0, 9'd1, 32'd5, 32'd2}};
    script[7] = '{OP_CLEAR, 8'd0,   16'd0,     1'b1, '{1'b0, 17'd0, 9'd0, 32'd0, 32'd0}};
    // Extremes first: empty buckets with no refill, max everything, tiny sweeping buckets; then mixed settings.
    phases[0] = '{16'd0,     32'd0,          32'd0,          25};
    phases[1] = '{16'd65535, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  120};
    phases[2] = '{16'd1,     32'd1,          32'd0,          25};
    phases[3] = '{16'd100,   32'd65536,      32'd60,         200};
    phases[4] = '{16'd5,     32'd6000,       32'd200,        180};
    phases[5] = '{16'd3,     32'd0,          32'd1000,       100};
    phases[6] = '{16'd65535, 32'd1,          32'd5000,       100};
    phases[7] = '{16'd2,     32'd70000,      32'd30,         120};
    phases[8] = '{16'd8,     32'd20000,      32'd80,         130};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (script[i]) begin
      issue(script[i].op, script[i].key, script[i].tok, script[i].typed, script[i].res);
      if (i % 3 == 2) pause(2);
    end
    drain();

    foreach (phases[p]) begin
      write_reg(CFG_CAPACITY, {16'd0, phases[p].cap});
      write_reg(CFG_RATE, phases[p].rate);
      write_reg(CFG_INTERVAL, phases[p].interval);
      burst = $urandom_range(16, 1);
      for (int n = 0; n < phases[p].items; n++) begin
        random_item(op, key, tok);
        issue(op, key, tok, 1'b0, '0);
        if (--burst == 0) begin
          burst = $urandom_range(16, 1);
          if ($urandom_range(9) == 0) drain();
          else if (p % 3 != 1) pause($urandom_range(5, 1));
        end
      end
      drain();
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
